>>> design/key_matrix_debounce_with_encoder_defines.svh
// ----------------------------------------------------------------------------
// key matrix debounce assertion macros
// shared concurrent assertion forms, clocked on clk, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_WITH_ENCODER_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCE_WITH_ENCODER_DEFINES_SVH

// same-cycle implication
`define KMDE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key matrix debounce: same-cycle check failed");

// next-cycle implication
`define KMDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key matrix debounce: next-cycle check failed");

`endif

>>> design/kmde_pkg.sv
// ----------------------------------------------------------------------------
// kmde_pkg
// sizes, register codes, reset values and shared types of the key debouncer
// ----------------------------------------------------------------------------
`default_nettype none

package kmde_pkg;

  // matrix geometry
  localparam int ROWS   = 4;
  localparam int COLS   = 12;
  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // field widths
  localparam int ROW_W      = 2;
  localparam int COL_W      = 4;
  localparam int TIME_W     = 16;
  localparam int HIST_W     = 8;
  localparam int STEP_W     = 3;
  localparam int ROW_BITS_W = 12;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_IDLE    = 2'd2;

  // configuration reset values
  localparam logic [HIST_W-1:0] PRESS_THR_RST   = 8'hFB;
  localparam logic [HIST_W-1:0] RELEASE_THR_RST = 8'h80 >> 5;
  localparam logic [TIME_W-1:0] ENC_IDLE_RST    = 16'd400;

  // sample bit shifted into the history
  localparam logic [HIST_W-1:0] PIN_SAMPLE = 8'h80;

  // encoder positions on the matrix
  localparam logic [ROW_W-1:0]  ENC_ROW      = 2'd3;
  localparam logic [COL_W-1:0]  ENC0_UP_COL  = 4'd0;
  localparam logic [COL_W-1:0]  ENC0_DN_COL  = 4'd4;
  localparam logic [COL_W-1:0]  ENC1_UP_COL  = 4'd6;
  localparam logic [COL_W-1:0]  ENC1_DN_COL  = 4'd11;
  localparam logic [COL_W-1:0]  ENC1_MIN_COL = 4'd5;
  localparam logic [STEP_W-1:0] STEP_ALL     = 3'b111;

  // sample presented to the encoder unit
  typedef struct packed {
    logic              fire;
    logic              inr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              pin;
    logic [TIME_W-1:0] now;
  } enc_req_t;

  // encoder unit answer
  typedef struct packed {
    logic hit;
    logic pulse;
  } enc_rsp_t;

endpackage

`default_nettype wire

>>> design/kmde_encoder.sv
// ----------------------------------------------------------------------------
// kmde_encoder
// rotary encoder step tracking: pin edges, shared step history, idle preset
// ----------------------------------------------------------------------------
`default_nettype none

module kmde_encoder (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire kmde_pkg::enc_req_t        req,
  input  wire logic [kmde_pkg::TIME_W-1:0] idle_ms,
  output kmde_pkg::enc_rsp_t             rsp
);
  import kmde_pkg::*;

  logic [3:0]        prev_r;
  logic [3:0]        prev_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [TIME_W-1:0] last_r;
  logic [TIME_W-1:0] last_nxt;

  logic              hit;
  logic              dir;
  logic              enc;
  logic [1:0]        pair_prev;
  logic              self_prev;
  logic              partner_prev;
  logic [STEP_W-1:0] target;
  logic [TIME_W-1:0] elapsed;
  logic [STEP_W-1:0] hist_pre;
  logic [STEP_W-1:0] hist_step;
  logic              release_ok;
  logic              pulse;

  // position decode and step logic
  always_comb begin
    hit = req.inr && (req.row == ENC_ROW) &&
          ((req.col == ENC0_UP_COL) || (req.col == ENC0_DN_COL) ||
           (req.col == ENC1_UP_COL) || (req.col == ENC1_DN_COL));
    dir          = (req.col == ENC0_UP_COL) || (req.col == ENC1_UP_COL);
    enc          = (req.col >= ENC1_MIN_COL);
    pair_prev    = enc ? prev_r[3:2] : prev_r[1:0];
    self_prev    = dir ? pair_prev[1] : pair_prev[0];
    partner_prev = dir ? pair_prev[0] : pair_prev[1];
    target       = dir ? STEP_ALL : '0;
    elapsed      = req.now - last_r;
    hist_pre     = (elapsed > idle_ms) ? target : step_r;
    hist_step    = {hist_pre[STEP_W-2:0], dir};
    release_ok   = (req.pin != self_prev) && !req.pin && !partner_prev;
    pulse        = hit && release_ok && (hist_step == target);
  end

  // next state
  always_comb begin
    prev_nxt = prev_r;
    step_nxt = step_r;
    last_nxt = last_r;
    if (req.fire && hit) begin
      prev_nxt[{enc, dir}] = req.pin;
      step_nxt             = release_ok ? hist_step : hist_pre;
      if (pulse) begin
        last_nxt = req.now;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      step_r <= '0;
      last_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      step_r <= step_nxt;
      last_r <= last_nxt;
    end
  end

  assign rsp.hit   = hit;
  assign rsp.pulse = pulse;

endmodule

`default_nettype wire

>>> design/key_matrix_debounce_with_encoder.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_with_encoder
// shift-register key debounce over a scanned matrix with two rotary encoders
// ----------------------------------------------------------------------------
// pipeline: the input transfer loads the update stage (history read), which
//   retires into the result register (update); a stalled result holds the stage
// throughput: 1 sample per cycle unless out_stall holds the result, set by the
//   history read-modify-write, forwarding between back-to-back same-key samples
// reset: synchronous, active low; clears all history valid bits, row states,
//   encoder state and loads the threshold and idle-time defaults
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_matrix_debounce_with_encoder_defines.svh"

module key_matrix_debounce_with_encoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [kmde_pkg::ROW_W-1:0]        in_row,
  input  wire logic [kmde_pkg::COL_W-1:0]        in_column,
  input  wire logic                              in_pin_active,
  input  wire logic [kmde_pkg::TIME_W-1:0]       in_now_ms,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic                              out_key_down,
  output      logic [kmde_pkg::ROW_BITS_W-1:0]   out_row_bits,
  output      logic                              out_encoder_pulse,
  input  wire logic                              cfg_we,
  input  wire logic [kmde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kmde_pkg::CFG_W-1:0]        cfg_wdata
);
  import kmde_pkg::*;

  // configuration
  logic [HIST_W-1:0] press_thr_r;
  logic [HIST_W-1:0] release_thr_r;
  logic [TIME_W-1:0] enc_idle_r;

  // history store
  logic [HIST_W-1:0] hist_mem [DEPTH];
  logic [DEPTH-1:0]  hist_vld_r;

  // update stage
  logic              s1_v_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_pin_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_inr_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [HIST_W-1:0] mem_q_r;
  logic              vld_q_r;
  logic              fwd_hit_r;
  logic [HIST_W-1:0] fwd_q_r;

  // debounced row states
  logic [COLS-1:0]   key_state_r [ROWS];

  // result register
  logic                  out_valid_r;
  logic                  out_key_down_r;
  logic [ROW_BITS_W-1:0] out_row_bits_r;
  logic                  out_pulse_r;

  logic              in_xfer;
  logic              s1_adv;
  logic              in_inr;
  logic [ADDR_W-1:0] in_addr;
  logic              s1_row_ok;
  logic [HIST_W-1:0] hist_old;
  logic [HIST_W-1:0] sample;
  logic [HIST_W-1:0] hist_new;
  logic [COLS-1:0]   row_old;
  logic [COLS-1:0]   row_new;
  logic              key_bit;
  logic              key_down_c;
  logic [ROW_BITS_W-1:0] row_bits_c;

  enc_req_t enc_req;
  enc_rsp_t enc_rsp;

  // handshake
  assign s1_adv    = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_v_r && !s1_adv;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // input address decode
  assign in_inr  = (int'(in_row) < ROWS) && (int'(in_column) < COLS);
  assign in_addr = ADDR_W'(int'(in_row) * COLS + int'(in_column));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_thr_r   <= PRESS_THR_RST;
      release_thr_r <= RELEASE_THR_RST;
      enc_idle_r    <= ENC_IDLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESS_THR:   press_thr_r   <= cfg_wdata[HIST_W-1:0];
        CFG_RELEASE_THR: release_thr_r <= cfg_wdata[HIST_W-1:0];
        CFG_ENC_IDLE:    enc_idle_r    <= cfg_wdata[TIME_W-1:0];
        default:         ;
      endcase
    end
  end

  // encoder unit
  assign enc_req.fire = s1_adv;
  assign enc_req.inr  = s1_v_r && s1_inr_r;
  assign enc_req.row  = s1_row_r;
  assign enc_req.col  = s1_col_r;
  assign enc_req.pin  = s1_pin_r;
  assign enc_req.now  = s1_now_r;

  kmde_encoder u_encoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (enc_req),
    .idle_ms (enc_idle_r),
    .rsp     (enc_rsp)
  );

  // history update and debounce decision
  always_comb begin
    s1_row_ok = (int'(s1_row_r) < ROWS);
    hist_old  = fwd_hit_r ? fwd_q_r : (vld_q_r ? mem_q_r : '0);
    if (enc_rsp.hit) begin
      sample = enc_rsp.pulse ? press_thr_r : '0;
    end else begin
      sample = s1_pin_r ? PIN_SAMPLE : '0;
    end
    hist_new = (hist_old >> 1) | sample;
    row_old  = s1_row_ok ? key_state_r[s1_row_r] : '0;
    if (hist_new >= press_thr_r) begin
      key_bit = 1'b1;
    end else if (hist_new <= release_thr_r) begin
      key_bit = 1'b0;
    end else begin
      key_bit = row_old[s1_col_r];
    end
    row_new = row_old;
    if (s1_inr_r) begin
      row_new[s1_col_r] = key_bit;
    end
    key_down_c = s1_inr_r && key_bit;
    for (int n = 0; n < ROW_BITS_W; n++) begin
      row_bits_c[n] = (n < COLS) ? row_new[n] : 1'b0;
    end
  end

  // history memory: read on input transfer, write when the update retires
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem_q_r <= hist_mem[in_inr ? in_addr : '0];
    end
    if (s1_adv && s1_inr_r) begin
      hist_mem[s1_addr_r] <= hist_new;
    end
  end

  // history valid bits and same-key forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      vld_q_r    <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        vld_q_r   <= in_inr && hist_vld_r[in_addr];
        fwd_hit_r <= s1_adv && s1_inr_r && in_inr && (s1_addr_r == in_addr);
      end
      if (s1_adv && s1_inr_r) begin
        hist_vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_q_r <= hist_new;
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_xfer) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_row_r  <= in_row;
      s1_col_r  <= in_column;
      s1_pin_r  <= in_pin_active;
      s1_now_r  <= in_now_ms;
      s1_inr_r  <= in_inr;
      s1_addr_r <= in_addr;
    end
  end

  // debounced row states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        key_state_r[r] <= '0;
      end
    end else if (s1_adv && s1_inr_r) begin
      key_state_r[s1_row_r] <= row_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_key_down_r <= key_down_c;
      out_row_bits_r <= row_bits_c;
      out_pulse_r    <= enc_rsp.pulse;
    end
  end

  assign out_key_down      = out_key_down_r;
  assign out_row_bits      = out_row_bits_r;
  assign out_encoder_pulse = out_pulse_r;

  // an encoder pulse always reads as a pressed key
  `KMDE_ASSERT_NOW(a_pulse_is_press, out_valid_r && out_pulse_r, out_key_down_r)

  // a held update stage keeps its address and read data
  `KMDE_ASSERT_NEXT(a_stage_hold, s1_v_r && !s1_adv,
                    s1_v_r && $stable(s1_addr_r) && $stable(mem_q_r) && $stable(fwd_hit_r))

  // a retiring update always leaves a result to be taken
  `KMDE_ASSERT_NEXT(a_retire_result, s1_adv, out_valid_r)

  // an ignored sample never reports a pressed key
  `KMDE_ASSERT_NEXT(a_ignored_quiet, s1_adv && !s1_inr_r,
                    !out_key_down_r && !out_pulse_r)

endmodule

`default_nettype wire
